/* hw/rtl/bqdec_pkg.sv */
// Package for the biquad IIR low-pass decimator.
// Register map codes, default widths and coefficient reset values.
// No dependencies.
package bqdec_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 24;
  localparam int COEF_FRAC_BITS_DEF = 16;

  // decimation step register and phase counter
  localparam int STEP_W   = 9;
  localparam int PHASE_W  = 8;
  localparam int STEP_MAX = 256;

  // APB-side widths
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 5;

  typedef enum logic [2:0] {
    REG_B0   = 3'd0,
    REG_B1   = 3'd1,
    REG_B2   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4,
    REG_STEP = 3'd5
  } reg_idx_t;

  // Butterworth low-pass set, Q2.16
  localparam int B0_Q16 = 1963;
  localparam int B1_Q16 = 3926;
  localparam int B2_Q16 = 1963;
  localparam int A1_Q16 = -95305;
  localparam int A2_Q16 = 37622;

  // rescale a Q2.16 value to Q2.frac
  function automatic longint coef_scale(input int q16, input int frac);
    longint v;
    v = longint'(q16);
    if (frac >= 16) begin
      return v <<< (frac - 16);
    end
    return v >>> (16 - frac);
  endfunction

endpackage

/* hw/rtl/biquad_iir_decimator.sv */
// Biquad IIR low-pass filter with integer decimation, top level.
// Depends on bqdec_pkg.
//
//  channel  | dir | ports                          | carries
//  ---------+-----+--------------------------------+-----------------------------
//  in_      | in  | in_tvalid/tready/tdata/tuser   | sample_in, block_start
//  out_     | out | out_tvalid/tready/tdata        | sample_out (decimated)
//  cfg_     | in  | APB psel/penable/pwrite/...    | coefficients, decim_step
//
//  One transfer per cycle is sustained. A sample is captured in the input
//  register, filtered from there (five multiplies, one sum, rounding,
//  saturation) and, if it is on the decimation phase, lands in the result
//  register; the feedback history is updated at that same clock edge.
//  rst_n is synchronous: it clears history, warmup, phase, valid flags and
//  restores the coefficient and step reset values.
//  Stalls: the pipeline holds only while a result waits in the output
//  register and out_tready is low.
module biquad_iir_decimator #(
  parameter int SAMPLE_WIDTH   = bqdec_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bqdec_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [SAMPLE_WIDTH-1:0] sample_in, zero padded to bytes
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   in_tdata,
  // [0] block_start
  input  logic                                in_tuser,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [SAMPLE_WIDTH-1:0] sample_out, zero padded to bytes
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   out_tdata,
  // configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [bqdec_pkg::CFG_AW-1:0]        cfg_paddr,
  input  logic [bqdec_pkg::CFG_DW-1:0]        cfg_pwdata,
  output logic [bqdec_pkg::CFG_DW-1:0]        cfg_prdata,
  output logic                                cfg_pready
);
  import bqdec_pkg::*;

  localparam int CW  = COEF_FRAC_BITS + 2;       // Q2.F coefficient
  localparam int PW  = CW + SAMPLE_WIDTH;        // one product
  localparam int AW  = PW + 3;                   // sum of five products
  localparam int SHW = AW - COEF_FRAC_BITS;      // after dropping fraction
  localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8;

  localparam logic signed [AW-1:0]  RND    = AW'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [SHW-1:0] SAT_HI = SHW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SHW-1:0] SAT_LO = -SAT_HI - SHW'(1);

  localparam logic signed [CW-1:0] B0_RST = CW'(coef_scale(B0_Q16, COEF_FRAC_BITS));
  localparam logic signed [CW-1:0] B1_RST = CW'(coef_scale(B1_Q16, COEF_FRAC_BITS));
  localparam logic signed [CW-1:0] B2_RST = CW'(coef_scale(B2_Q16, COEF_FRAC_BITS));
  localparam logic signed [CW-1:0] A1_RST = CW'(coef_scale(A1_Q16, COEF_FRAC_BITS));
  localparam logic signed [CW-1:0] A2_RST = CW'(coef_scale(A2_Q16, COEF_FRAC_BITS));

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic signed [CW-1:0] coef_b0_r, coef_b1_r, coef_b2_r, coef_a1_r, coef_a2_r;
  logic [STEP_W-1:0]    decim_step_r;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b0_r    <= B0_RST;
      coef_b1_r    <= B1_RST;
      coef_b2_r    <= B2_RST;
      coef_a1_r    <= A1_RST;
      coef_a2_r    <= A2_RST;
      decim_step_r <= STEP_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_B0:   coef_b0_r    <= signed'(cfg_pwdata[CW-1:0]);
        REG_B1:   coef_b1_r    <= signed'(cfg_pwdata[CW-1:0]);
        REG_B2:   coef_b2_r    <= signed'(cfg_pwdata[CW-1:0]);
        REG_A1:   coef_a1_r    <= signed'(cfg_pwdata[CW-1:0]);
        REG_A2:   coef_a2_r    <= signed'(cfg_pwdata[CW-1:0]);
        REG_STEP: decim_step_r <= cfg_pwdata[STEP_W-1:0];
        default:  ;  // unmapped addresses are ignored
      endcase
    end
  end

  // coefficients read back sign extended, step zero extended
  always_comb begin
    unique case (cfg_idx)
      REG_B0:   cfg_prdata = CFG_DW'(coef_b0_r);
      REG_B1:   cfg_prdata = CFG_DW'(coef_b1_r);
      REG_B2:   cfg_prdata = CFG_DW'(coef_b2_r);
      REG_A1:   cfg_prdata = CFG_DW'(coef_a1_r);
      REG_A2:   cfg_prdata = CFG_DW'(coef_a2_r);
      REG_STEP: cfg_prdata = CFG_DW'(decim_step_r);
      default:  cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Handshake: input register -> filter -> result register
  // ---------------------------------------------------------------------
  logic                           s1_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_x_r;
  logic                           s1_start_r;
  logic                           out_valid_r;
  logic [SAMPLE_WIDTH-1:0]        out_sample_r;
  logic                           adv;
  logic                           fire;
  logic                           in_xfer;

  assign adv       = !out_valid_r || out_tready;  // result register free next edge
  assign fire      = s1_valid_r && adv;
  assign in_tready = !s1_valid_r || adv;
  assign in_xfer   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDW'(out_sample_r);

  // ---------------------------------------------------------------------
  // Filter state
  // ---------------------------------------------------------------------
  logic signed [SAMPLE_WIDTH-1:0] hist_in1_r, hist_in2_r, hist_out1_r, hist_out2_r;
  logic [1:0]                     warm_cnt_r;
  logic [PHASE_W-1:0]             phase_cnt_r;

  logic [1:0]                     warm_eff, warm_nxt;
  logic [PHASE_W-1:0]             phase_eff, phase_cnt_nxt;
  logic [PHASE_W:0]               phase_inc;
  logic [STEP_W-1:0]              step_eff;
  logic                           emit;

  logic signed [PW-1:0]           p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [AW-1:0]           acc;
  logic signed [SHW-1:0]          acc_sh;
  logic signed [SAMPLE_WIDTH-1:0] y_filt, y;

  // zero counts as 1, anything above the maximum as the maximum
  always_comb begin
    if (decim_step_r == '0) begin
      step_eff = STEP_W'(1);
    end else if (decim_step_r > STEP_W'(STEP_MAX)) begin
      step_eff = STEP_W'(STEP_MAX);
    end else begin
      step_eff = decim_step_r;
    end
  end

  // block_start restarts warmup and phase at this very sample
  assign warm_eff  = s1_start_r ? 2'd0 : warm_cnt_r;
  assign phase_eff = s1_start_r ? '0 : phase_cnt_r;
  assign warm_nxt  = (warm_eff < 2'd2) ? warm_eff + 2'd1 : warm_eff;
  assign emit      = (phase_eff == '0);
  assign phase_inc = {1'b0, phase_eff} + (PHASE_W + 1)'(1);
  assign phase_cnt_nxt = (phase_inc >= step_eff) ? '0 : phase_inc[PHASE_W-1:0];

  // direct form I: b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2
  assign p_b0 = coef_b0_r * s1_x_r;
  assign p_b1 = coef_b1_r * hist_in1_r;
  assign p_b2 = coef_b2_r * hist_in2_r;
  assign p_a1 = coef_a1_r * hist_out1_r;
  assign p_a2 = coef_a2_r * hist_out2_r;

  assign acc    = AW'(p_b0) + AW'(p_b1) + AW'(p_b2) - AW'(p_a1) - AW'(p_a2) + RND;
  assign acc_sh = signed'(acc[AW-1:COEF_FRAC_BITS]);  // floor shift, ties round up

  always_comb begin
    if (acc_sh > SAT_HI) begin
      y_filt = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (acc_sh < SAT_LO) begin
      y_filt = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      y_filt = acc_sh[SAMPLE_WIDTH-1:0];
    end
  end

  // first two samples of a block pass straight through
  assign y = (warm_eff < 2'd2) ? s1_x_r : y_filt;

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hist_in1_r  <= '0;
      hist_in2_r  <= '0;
      hist_out1_r <= '0;
      hist_out2_r <= '0;
      warm_cnt_r  <= '0;
      phase_cnt_r <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= fire && emit;
      end
      if (fire) begin
        hist_in2_r  <= hist_in1_r;
        hist_in1_r  <= s1_x_r;
        hist_out2_r <= hist_out1_r;
        hist_out1_r <= y;
        warm_cnt_r  <= warm_nxt;
        phase_cnt_r <= phase_cnt_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_x_r     <= signed'(in_tdata[SAMPLE_WIDTH-1:0]);
      s1_start_r <= in_tuser;
    end
    if (fire && emit) begin
      out_sample_r <= y;
    end
  end

endmodule

/* hw/rtl/bqdec_checker.sv */
// Port-level checker for biquad_iir_decimator, with its bind statement.
// Depends on bqdec_pkg.
module bqdec_checker #(
  parameter int SAMPLE_WIDTH   = bqdec_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bqdec_pkg::COEF_FRAC_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [((SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,
  input logic                              in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [((SAMPLE_WIDTH+7)/8)*8-1:0] out_tdata,
  input logic                              cfg_psel,
  input logic                              cfg_penable,
  input logic                              cfg_pwrite,
  input logic [bqdec_pkg::CFG_AW-1:0]      cfg_paddr,
  input logic [bqdec_pkg::CFG_DW-1:0]      cfg_pwdata,
  input logic [bqdec_pkg::CFG_DW-1:0]      cfg_prdata,
  input logic                              cfg_pready
);
  import bqdec_pkg::*;

  localparam int CW = COEF_FRAC_BITS + 2;

  // an offered sample holds until its transfer
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("input changed while stalled");

  // a waiting result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no result straight after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // input only backs up when a result is stuck at the output
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output back-pressure");

  // a coefficient write reads back on the next cycle
  a_coef_rb: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
      && (cfg_paddr[4:2] < REG_STEP) ##1 $past(rst_n)
      && cfg_psel && !cfg_pwrite && (cfg_paddr == $past(cfg_paddr))
    |-> cfg_prdata[CW-1:0] == $past(cfg_pwdata[CW-1:0]))
    else $error("coefficient read-back mismatch");

endmodule

bind biquad_iir_decimator bqdec_checker #(
  .SAMPLE_WIDTH  (SAMPLE_WIDTH),
  .COEF_FRAC_BITS(COEF_FRAC_BITS)
) u_bqdec_checker (.*);
